FILE: hw/rtl/vrp_pkg.sv
// shared types, constants and widths for the vertex to raster projection block
package vrp_pkg;

	localparam int MAX_WINDOW_DIM = 4096;
	localparam int PIX_W          = 12;
	localparam int PIXEL_MAX      = (1 << PIX_W) - 1;
	localparam int DIM_W          = 13;
	localparam int COEF_W         = 16;
	localparam int POS_W          = 32;
	localparam int PROD_W         = COEF_W + POS_W;
	localparam int ACC_W          = PROD_W + 2;
	localparam int NUM_W          = ACC_W + 2;
	localparam int DEN_W          = ACC_W + 1;
	localparam int DIVD_W         = DEN_W + PIX_W;
	localparam int ROW_W          = 4 * COEF_W;
	localparam int CFG_IDX_W      = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW0   = 3'd0,
		REG_ROW1   = 3'd1,
		REG_ROW2   = 3'd2,
		REG_ROW3   = 3'd3,
		REG_WIDTH  = 3'd4,
		REG_HEIGHT = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		SEL_ZERO = 2'd0,
		SEL_SPAN = 2'd1,
		SEL_DIV  = 2'd2
	} pix_sel_t;

	typedef struct packed {
		pix_sel_t         sel;
		logic [PIX_W-1:0] span;
	} map_ctl_t;

	// effective pixel span of a window size register
	function automatic logic [PIX_W-1:0] span_of(input logic [DIM_W-1:0] d);
		logic [DIM_W:0] e;
		e = {1'b0, d};
		if (e == '0)
			e = (DIM_W+1)'(1);
		if (e > (DIM_W+1)'(MAX_WINDOW_DIM))
			e = (DIM_W+1)'(MAX_WINDOW_DIM);
		e = e - (DIM_W+1)'(1);
		if (e > (DIM_W+1)'(PIXEL_MAX))
			e = (DIM_W+1)'(PIXEL_MAX);
		return e[PIX_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/vrp_transform.sv
// matrix row products and sums for clip x, y and w (two stages)
module vrp_transform (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [vrp_pkg::POS_W-1:0]      pos_x,
	input  logic signed [vrp_pkg::POS_W-1:0]      pos_y,
	input  logic signed [vrp_pkg::POS_W-1:0]      pos_z,
	input  logic [vrp_pkg::ROW_W-1:0]             row_x,
	input  logic [vrp_pkg::ROW_W-1:0]             row_y,
	input  logic [vrp_pkg::ROW_W-1:0]             row_w,
	output logic signed [vrp_pkg::ACC_W-1:0]      cx_s2,
	output logic signed [vrp_pkg::ACC_W-1:0]      cy_s2,
	output logic signed [vrp_pkg::ACC_W-1:0]      cw_s2
);
	import vrp_pkg::*;

	logic [ROW_W-1:0]         rows [3];
	logic signed [POS_W-1:0]  pos [3];
	logic signed [PROD_W-1:0] prod_s1 [3][4];
	logic signed [ACC_W-1:0]  sum [3];

	assign rows[0] = row_x;
	assign rows[1] = row_y;
	assign rows[2] = row_w;
	assign pos[0]  = pos_x;
	assign pos[1]  = pos_y;
	assign pos[2]  = pos_z;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++)
					prod_s1[r][c] <= PROD_W'(signed'(rows[r][COEF_W*c +: COEF_W]))
						* PROD_W'(pos[c]);
				// constant column times one in q16.16
				prod_s1[r][3] <= signed'({{(PROD_W-COEF_W-16){rows[r][ROW_W-1]}},
					rows[r][ROW_W-1 -: COEF_W], 16'b0});
			end
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++)
			sum[r] = ACC_W'(prod_s1[r][0]) + ACC_W'(prod_s1[r][1])
				+ ACC_W'(prod_s1[r][2]) + ACC_W'(prod_s1[r][3]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s2 <= sum[0];
			cy_s2 <= sum[1];
			cw_s2 <= sum[2];
		end
	end

endmodule

FILE: hw/rtl/vrp_clip.sv
// clip clamp, w raise, screen numerators and span scaling (two stages)
module vrp_clip (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [vrp_pkg::ACC_W-1:0]   cx,
	input  logic signed [vrp_pkg::ACC_W-1:0]   cy,
	input  logic signed [vrp_pkg::ACC_W-1:0]   cw,
	input  logic [vrp_pkg::PIX_W-1:0]          span_x,
	input  logic [vrp_pkg::PIX_W-1:0]          span_y,
	output logic [vrp_pkg::DIVD_W-1:0]         divd_x_s4,
	output logic [vrp_pkg::DIVD_W-1:0]         divd_y_s4,
	output logic [vrp_pkg::DEN_W-1:0]          den_s4,
	output vrp_pkg::map_ctl_t                  ctl_x_s4,
	output vrp_pkg::map_ctl_t                  ctl_y_s4
);
	import vrp_pkg::*;

	logic signed [NUM_W-1:0] w, nw, x1, x2, y1, y2, wp;
	logic signed [NUM_W-1:0] num_x_s3, num_y_s3;
	logic [DEN_W-1:0]        den_s3;
	logic signed [NUM_W-1:0] den_ext;

	always_comb begin
		w  = NUM_W'(cw);
		nw = -w;
		x1 = (NUM_W'(cx) > w) ? w : NUM_W'(cx);
		x2 = (x1 < nw) ? nw : x1;
		y1 = (NUM_W'(cy) > w) ? w : NUM_W'(cy);
		y2 = (y1 < nw) ? nw : y1;
		wp = (w > 0) ? w : NUM_W'(1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_x_s3 <= x2 + wp;
			num_y_s3 <= wp - y2;
			den_s3   <= {wp[DEN_W-2:0], 1'b0};
		end
	end

	assign den_ext = signed'(NUM_W'(den_s3));

	function automatic pix_sel_t pick(input logic signed [NUM_W-1:0] n,
		input logic signed [NUM_W-1:0] d);
		if (n <= 0)
			return SEL_ZERO;
		else if (n >= d)
			return SEL_SPAN;
		return SEL_DIV;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			divd_x_s4     <= DIVD_W'(num_x_s3[DEN_W-1:0]) * DIVD_W'(span_x);
			divd_y_s4     <= DIVD_W'(num_y_s3[DEN_W-1:0]) * DIVD_W'(span_y);
			den_s4        <= den_s3;
			ctl_x_s4.sel  <= pick(num_x_s3, den_ext);
			ctl_x_s4.span <= span_x;
			ctl_y_s4.sel  <= pick(num_y_s3, den_ext);
			ctl_y_s4.span <= span_y;
		end
	end

endmodule

FILE: hw/rtl/vrp_divider.sv
// pipelined restoring divider, one quotient bit per stage, with edge select
module vrp_divider (
	input  logic                          clk,
	input  logic                          en,
	input  logic [vrp_pkg::DIVD_W-1:0]    divd,
	input  logic [vrp_pkg::DEN_W-1:0]     den,
	input  vrp_pkg::map_ctl_t             ctl,
	output logic [vrp_pkg::PIX_W-1:0]     pixel
);
	import vrp_pkg::*;

	logic [DEN_W-1:0] rem_q [PIX_W+1];
	logic [PIX_W-1:0] lo_q  [PIX_W+1];
	logic [PIX_W-1:0] quo_q [PIX_W+1];
	logic [DEN_W-1:0] den_q [PIX_W+1];
	map_ctl_t         ctl_q [PIX_W+1];

	// quotient fits in PIX_W bits, so the top part starts below the divisor
	assign rem_q[0] = divd[DIVD_W-1:PIX_W];
	assign lo_q[0]  = divd[PIX_W-1:0];
	assign quo_q[0] = '0;
	assign den_q[0] = den;
	assign ctl_q[0] = ctl;

	for (genvar i = 0; i < PIX_W; i++) begin : g_step
		logic [DEN_W:0] t;
		logic           ge;
		assign t  = {rem_q[i], lo_q[i][PIX_W-1]};
		assign ge = t >= {1'b0, den_q[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i+1] <= ge ? DEN_W'(t - {1'b0, den_q[i]}) : t[DEN_W-1:0];
				lo_q[i+1]  <= {lo_q[i][PIX_W-2:0], 1'b0};
				quo_q[i+1] <= {quo_q[i][PIX_W-2:0], ge};
				den_q[i+1] <= den_q[i];
				ctl_q[i+1] <= ctl_q[i];
			end
		end
	end

	always_comb begin
		case (ctl_q[PIX_W].sel)
			SEL_DIV:  pixel = quo_q[PIX_W];
			SEL_SPAN: pixel = ctl_q[PIX_W].span;
			default:  pixel = '0;
		endcase
	end

endmodule

FILE: hw/rtl/vertex_to_raster_projection.sv
// vertex to raster projection: transform, clip clamp and viewport mapping
//
// Input channel in_valid/in_stall carries one point: kind and node tags and
// a signed q16.16 position. Output channel out_valid/out_stall carries the
// copied tags and the raster pixel column and row (row counted from top).
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data) for the
// four matrix rows and the window size; write it only while no item is in
// flight.
// From acceptance to out_valid an item passes two transform stages, two
// clamp and scale stages, twelve divider stages (one quotient bit each)
// and the output register. One item is taken every cycle while the output
// is not stalled.
// When out_stall holds a valid result, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and loads the default matrix and window size.
module vertex_to_raster_projection (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [vrp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vrp_pkg::ROW_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         point_kind,
	input  logic [23:0]                        node_id,
	input  logic signed [vrp_pkg::POS_W-1:0]   pos_x,
	input  logic signed [vrp_pkg::POS_W-1:0]   pos_y,
	input  logic signed [vrp_pkg::POS_W-1:0]   pos_z,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [7:0]                         kind_out,
	output logic [23:0]                        node_out,
	output logic [vrp_pkg::PIX_W-1:0]          pixel_x,
	output logic [vrp_pkg::PIX_W-1:0]          pixel_y
);
	import vrp_pkg::*;

	localparam int DEPTH = 4 + PIX_W + 1;

	logic [ROW_W-1:0] row0_q, row1_q, row2_q, row3_q;
	logic [DIM_W-1:0] width_q, height_q;
	logic             en;
	logic [DEPTH-1:0] v_q;
	logic [31:0]      tag_q [DEPTH];
	logic [PIX_W-1:0] span_x, span_y;

	logic signed [ACC_W-1:0] cx_s2, cy_s2, cw_s2;
	logic [DIVD_W-1:0]       divd_x_s4, divd_y_s4;
	logic [DEN_W-1:0]        den_s4;
	map_ctl_t                ctl_x_s4, ctl_y_s4;
	logic [PIX_W-1:0]        px, py;
	logic [PIX_W-1:0]        pixel_x_q, pixel_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_q   <= ROW_W'(64'd4096);
			row1_q   <= ROW_W'(64'd268435456);
			row2_q   <= ROW_W'(64'd17592186044416);
			row3_q   <= ROW_W'(64'd1152921504606846976);
			width_q  <= DIM_W'(306);
			height_q <= DIM_W'(256);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW0:   row0_q   <= cfg_data;
				REG_ROW1:   row1_q   <= cfg_data;
				REG_ROW2:   row2_q   <= cfg_data;
				REG_ROW3:   row3_q   <= cfg_data;
				REG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign span_x = span_of(width_q);
	assign span_y = span_of(height_q);

	assign en       = !(v_q[DEPTH-1] && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else if (en)
			v_q <= {v_q[DEPTH-2:0], in_valid};
	end

	// tags ride alongside the arithmetic
	always_ff @(posedge clk) begin
		if (en) begin
			tag_q[0] <= {point_kind, node_id};
			for (int i = 1; i < DEPTH; i++)
				tag_q[i] <= tag_q[i-1];
		end
	end

	vrp_transform u_transform (
		.clk   (clk),
		.en    (en),
		.pos_x (pos_x),
		.pos_y (pos_y),
		.pos_z (pos_z),
		.row_x (row0_q),
		.row_y (row1_q),
		.row_w (row3_q),
		.cx_s2 (cx_s2),
		.cy_s2 (cy_s2),
		.cw_s2 (cw_s2)
	);

	vrp_clip u_clip (
		.clk       (clk),
		.en        (en),
		.cx        (cx_s2),
		.cy        (cy_s2),
		.cw        (cw_s2),
		.span_x    (span_x),
		.span_y    (span_y),
		.divd_x_s4 (divd_x_s4),
		.divd_y_s4 (divd_y_s4),
		.den_s4    (den_s4),
		.ctl_x_s4  (ctl_x_s4),
		.ctl_y_s4  (ctl_y_s4)
	);

	vrp_divider u_div_x (
		.clk   (clk),
		.en    (en),
		.divd  (divd_x_s4),
		.den   (den_s4),
		.ctl   (ctl_x_s4),
		.pixel (px)
	);

	vrp_divider u_div_y (
		.clk   (clk),
		.en    (en),
		.divd  (divd_y_s4),
		.den   (den_s4),
		.ctl   (ctl_y_s4),
		.pixel (py)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			pixel_x_q <= px;
			pixel_y_q <= py;
		end
	end

	assign out_valid = v_q[DEPTH-1];
	assign kind_out  = tag_q[DEPTH-1][31:24];
	assign node_out  = tag_q[DEPTH-1][23:0];
	assign pixel_x   = pixel_x_q;
	assign pixel_y   = pixel_y_q;

	// row2_q is held for the register map but has no effect on the pixels
	logic row2_unused;
	assign row2_unused = ^row2_q;

	a_in_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_q[0])
		else $error("accepted item missing from first stage");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(v_q) && $stable(pixel_x) && $stable(pixel_y))
		else $error("pipeline moved during output stall");

	a_pix_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pixel_x <= span_x && pixel_y <= span_y)
		else $error("pixel beyond window span");

endmodule
